// ===== design/tasdg_pkg.sv =====
`timescale 1ns / 1ps

package tasdg_pkg;

	// Request codes (code 3 is unused and behaves as a tick)
	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_MOVE = 2'd1;
	localparam logic [1:0] REQ_SET  = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_TICK     = 2'd0;
	localparam logic [1:0] ST_ACCEPTED = 2'd1;
	localparam logic [1:0] ST_BUSY     = 2'd2;
	localparam logic [1:0] ST_NOT_RDY  = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_DRIVER_READY = 2'd0;
	localparam logic [1:0] CFG_PULSE_HIGH   = 2'd1;
	localparam logic [1:0] CFG_STEP_PERIOD  = 2'd2;
	localparam logic [1:0] CFG_DIR_SETUP    = 2'd3;

	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 20;
	localparam int TICKS_W     = 16;
	localparam int TIMER_W     = 20;
	localparam int VALUE_W     = 32;

	// Register reset values
	localparam logic [TICKS_W-1:0] PULSE_HIGH_RST  = 16'd20;
	localparam logic [TICKS_W-1:0] STEP_PERIOD_RST = 16'd1000;
	localparam logic [TIMER_W-1:0] DIR_SETUP_RST   = 20'd5000;

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_PAN_SETUP  = 3'd1,
		PH_PAN_HIGH   = 3'd2,
		PH_PAN_LOW    = 3'd3,
		PH_TILT_SETUP = 3'd4,
		PH_TILT_HIGH  = 3'd5,
		PH_TILT_LOW   = 3'd6
	} phase_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [VALUE_W-1:0] pan_value;
		logic [VALUE_W-1:0] tilt_value;
	} item_t;

	typedef struct packed {
		logic               step_pan_out;
		logic               dir_pan_out;
		logic               step_tilt_out;
		logic               dir_tilt_out;
		logic               busy_res;
		logic               done_res;
		logic [1:0]         status;
		logic [VALUE_W-1:0] pan_position;
		logic [VALUE_W-1:0] tilt_position;
	} result_t;

endpackage

// ===== design/tasdg_in_reg.sv =====
`timescale 1ns / 1ps

module tasdg_in_reg import tasdg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  item_valid,
	input  logic  item_take,
	output item_t item
);

	logic  valid_q;
	item_t item_s1;

	// Load when empty or when the held beat leaves this cycle
	assign in_ready   = !valid_q || item_take;
	assign item_valid = valid_q;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_q <= 1'b1;
		end else if (item_take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== design/tasdg_core.sv =====
`timescale 1ns / 1ps

module tasdg_core import tasdg_pkg::*; #(
	parameter int POSITION_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  item_valid,
	output logic                  item_take,
	input  item_t                 item,
	output logic                  res_valid,
	input  logic                  res_ready,
	output result_t               res
);

	localparam int PW = POSITION_WIDTH;

	// Configuration registers
	logic               drv_ready_q;
	logic [TICKS_W-1:0] pulse_high_q;
	logic [TICKS_W-1:0] period_q;
	logic [TIMER_W-1:0] setup_q;

	// Move state
	phase_t               phase_q, phase_n;
	logic [TIMER_W-1:0]   timer_q, timer_n;
	logic [PW-1:0]        steps_q, steps_n;
	logic signed [PW-1:0] tgt_pan_q, tgt_pan_n;
	logic signed [PW-1:0] tgt_tilt_q, tgt_tilt_n;
	logic                 tilt_nz_q, tilt_nz_n;
	logic                 tilt_neg_q, tilt_neg_n;
	logic [PW-1:0]        tilt_mag_q, tilt_mag_n;
	logic signed [PW-1:0] pan_pos_q, pan_pos_n;
	logic signed [PW-1:0] tilt_pos_q, tilt_pos_n;
	logic [1:0]           dir_q, dir_n;

	logic    res_valid_q;
	result_t res_q;

	// Per-item decode and parallel delta arithmetic
	logic signed [VALUE_W-1:0] pv_in, tv_in;
	logic signed [PW-1:0]      pv, tv;
	logic                      is_set, is_cmd;
	logic signed [PW-1:0]      pan_d, pan_nd, tilt_d, tilt_nd;
	logic signed [PW-1:0]      pan_tgt, tilt_tgt;
	logic                      pan_nz, pan_neg, tilt_nz, tilt_neg;
	logic [PW-1:0]             pan_mag, tilt_mag, steps_dec;
	logic [TICKS_W-1:0]        high_len, low_len;

	logic       step_pan, step_tilt, done;
	logic [1:0] status;

	assign item_take = item_valid && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign pv_in  = item.pan_value;
	assign tv_in  = item.tilt_value;
	assign pv     = PW'(pv_in);
	assign tv     = PW'(tv_in);
	assign is_set = (item.req_type == REQ_SET);
	assign is_cmd = (item.req_type == REQ_MOVE) || is_set;

	// Delta, negated delta and final target computed side by side
	assign pan_d    = is_set ? pv - pan_pos_q : pv;
	assign pan_nd   = is_set ? pan_pos_q - pv : -pv;
	assign pan_tgt  = is_set ? pv : pan_pos_q + pv;
	assign tilt_d   = is_set ? tv - tilt_pos_q : tv;
	assign tilt_nd  = is_set ? tilt_pos_q - tv : -tv;
	assign tilt_tgt = is_set ? tv : tilt_pos_q + tv;
	assign pan_nz   = (pan_d != '0);
	assign pan_neg  = pan_d[PW-1];
	assign pan_mag  = pan_neg ? pan_nd : pan_d;
	assign tilt_nz  = (tilt_d != '0);
	assign tilt_neg = tilt_d[PW-1];
	assign tilt_mag = tilt_neg ? tilt_nd : tilt_d;

	// Phase lengths
	assign high_len  = (pulse_high_q == '0) ? TICKS_W'(1) : pulse_high_q;
	assign low_len   = (period_q > high_len) ? period_q - high_len : TICKS_W'(1);
	assign steps_dec = (steps_q != '0) ? steps_q - PW'(1) : '0;

	// Next state and result fields
	always_comb begin
		phase_n    = phase_q;
		timer_n    = timer_q;
		steps_n    = steps_q;
		tgt_pan_n  = tgt_pan_q;
		tgt_tilt_n = tgt_tilt_q;
		tilt_nz_n  = tilt_nz_q;
		tilt_neg_n = tilt_neg_q;
		tilt_mag_n = tilt_mag_q;
		pan_pos_n  = pan_pos_q;
		tilt_pos_n = tilt_pos_q;
		dir_n      = dir_q;
		step_pan   = 1'b0;
		step_tilt  = 1'b0;
		done       = 1'b0;
		status     = ST_TICK;

		if (is_cmd) begin
			if (!drv_ready_q) begin
				status = ST_NOT_RDY;
			end else if (phase_q != PH_IDLE) begin
				status = ST_BUSY;
			end else begin
				status     = ST_ACCEPTED;
				tgt_pan_n  = pan_tgt;
				tgt_tilt_n = tilt_tgt;
				tilt_nz_n  = tilt_nz;
				tilt_neg_n = tilt_neg;
				tilt_mag_n = tilt_mag;
				if (pan_nz) begin
					dir_n[0] = !pan_neg;
					steps_n  = pan_mag;
					if (setup_q != '0) begin
						phase_n = PH_PAN_SETUP;
						timer_n = setup_q;
					end else begin
						phase_n = PH_PAN_HIGH;
						timer_n = TIMER_W'(high_len);
					end
				end else if (tilt_nz) begin
					dir_n[1] = !tilt_neg;
					steps_n  = tilt_mag;
					if (setup_q != '0) begin
						phase_n = PH_TILT_SETUP;
						timer_n = setup_q;
					end else begin
						phase_n = PH_TILT_HIGH;
						timer_n = TIMER_W'(high_len);
					end
				end else begin
					// Both deltas zero: done at once, positions unchanged
					done = 1'b1;
				end
			end
		end else if (phase_q != PH_IDLE) begin
			step_pan  = (phase_q == PH_PAN_HIGH);
			step_tilt = (phase_q == PH_TILT_HIGH);
			if (timer_q > TIMER_W'(1)) begin
				timer_n = timer_q - TIMER_W'(1);
			end else begin
				case (phase_q)
					PH_PAN_SETUP, PH_TILT_SETUP: begin
						phase_n = phase_t'(phase_q + 3'd1);
						timer_n = TIMER_W'(high_len);
					end
					PH_PAN_HIGH, PH_TILT_HIGH: begin
						phase_n = phase_t'(phase_q + 3'd1);
						timer_n = TIMER_W'(low_len);
					end
					PH_PAN_LOW, PH_TILT_LOW: begin
						steps_n = steps_dec;
						if (steps_dec != '0) begin
							phase_n = phase_t'(phase_q - 3'd1);
							timer_n = TIMER_W'(high_len);
						end else if (phase_q == PH_PAN_LOW && tilt_nz_q) begin
							dir_n[1] = !tilt_neg_q;
							steps_n  = tilt_mag_q;
							if (setup_q != '0) begin
								phase_n = PH_TILT_SETUP;
								timer_n = setup_q;
							end else begin
								phase_n = PH_TILT_HIGH;
								timer_n = TIMER_W'(high_len);
							end
						end else begin
							// Move complete: commit positions
							pan_pos_n  = tgt_pan_q;
							tilt_pos_n = tgt_tilt_q;
							phase_n    = PH_IDLE;
							timer_n    = '0;
							steps_n    = '0;
							done       = 1'b1;
						end
					end
					default: begin
						phase_n = PH_IDLE;
						timer_n = '0;
					end
				endcase
			end
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_ready_q  <= 1'b1;
			pulse_high_q <= PULSE_HIGH_RST;
			period_q     <= STEP_PERIOD_RST;
			setup_q      <= DIR_SETUP_RST;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				CFG_DRIVER_READY: drv_ready_q  <= cfg_wdata[0];
				CFG_PULSE_HIGH:   pulse_high_q <= cfg_wdata[TICKS_W-1:0];
				CFG_STEP_PERIOD:  period_q     <= cfg_wdata[TICKS_W-1:0];
				CFG_DIR_SETUP:    setup_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Move state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			timer_q    <= '0;
			steps_q    <= '0;
			tgt_pan_q  <= '0;
			tgt_tilt_q <= '0;
			tilt_nz_q  <= 1'b0;
			tilt_neg_q <= 1'b0;
			tilt_mag_q <= '0;
			pan_pos_q  <= '0;
			tilt_pos_q <= '0;
			dir_q      <= '0;
		end else if (item_take) begin
			phase_q    <= phase_n;
			timer_q    <= timer_n;
			steps_q    <= steps_n;
			tgt_pan_q  <= tgt_pan_n;
			tgt_tilt_q <= tgt_tilt_n;
			tilt_nz_q  <= tilt_nz_n;
			tilt_neg_q <= tilt_neg_n;
			tilt_mag_q <= tilt_mag_n;
			pan_pos_q  <= pan_pos_n;
			tilt_pos_q <= tilt_pos_n;
			dir_q      <= dir_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (item_take) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			res_q.step_pan_out  <= step_pan;
			res_q.dir_pan_out   <= dir_n[0];
			res_q.step_tilt_out <= step_tilt;
			res_q.dir_tilt_out  <= dir_n[1];
			res_q.busy_res      <= (phase_n != PH_IDLE);
			res_q.done_res      <= done;
			res_q.status        <= status;
			res_q.pan_position  <= VALUE_W'(pan_pos_n);
			res_q.tilt_position <= VALUE_W'(tilt_pos_n);
		end
	end

	// Checks
	a_idle_timer_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (timer_q == '0))
		else $error("timer not clear while idle");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.done_res) |-> !res_q.busy_res)
		else $error("move reported done while still busy");

	a_one_step_axis: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.step_pan_out && res_q.step_tilt_out))
		else $error("both axes stepping at once");

	a_cmd_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status != ST_TICK)
			|-> (!res_q.step_pan_out && !res_q.step_tilt_out))
		else $error("step pulse on a command beat");

	a_pos_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(item_take && done) |=> ($stable(pan_pos_q) && $stable(tilt_pos_q)))
		else $error("position changed without move completion");

endmodule

// ===== design/two_axis_step_dir_generator_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Signals                         Content
// s_*       in         s_tvalid s_tready s_tdata s_tuser  tick or move/set command
// m_*       out        m_tvalid m_tready m_tdata m_tuser  output levels, status, positions
// cfg_*     in         cfg_wr_en cfg_addr cfg_wdata     register writes, no read-back
//
// Every beat (tick or command) is handled by the step engine;
// a new beat can be taken every clock while m does not stall, so one beat per cycle sustained.
// A beat passes the input register, then the result register, from s to m.
// A stall on m holds the result register; s_tready drops once the input
// register holds a beat.
// arst_n clears handshakes, move state and positions and restores register
// defaults; no clearing pass is needed.

module two_axis_step_dir_generator_core import tasdg_pkg::*; #(
	parameter int POSITION_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [63:0]           s_tdata,  // pan_value[31:0], tilt_value[63:32]
	input  logic [1:0]            s_tuser,  // req_type[1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// step_pan_out[0], dir_pan_out[1], step_tilt_out[2], dir_tilt_out[3],
	// busy_res[4], done_res[5], pan_position[37:6], tilt_position[69:38], zero fill
	output logic [71:0]           m_tdata,
	output logic [1:0]            m_tuser   // status[1:0]
);

	item_t   in_item, item;
	logic    item_valid, item_take;
	result_t res;

	assign in_item.req_type   = s_tuser;
	assign in_item.pan_value  = s_tdata[31:0];
	assign in_item.tilt_value = s_tdata[63:32];

	tasdg_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (in_item),
		.item_valid (item_valid),
		.item_take  (item_take),
		.item       (item)
	);

	tasdg_core #(
		.POSITION_WIDTH (POSITION_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item_take  (item_take),
		.item       (item),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	// Result beat packing
	assign m_tdata = {2'b00, res.tilt_position, res.pan_position, res.done_res, res.busy_res,
		res.dir_tilt_out, res.step_tilt_out, res.dir_pan_out, res.step_pan_out};
	assign m_tuser = res.status;

endmodule

// ===== tb/step_dir_checker.sv =====
`timescale 1ns / 1ps

module step_dir_checker import tasdg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [63:0]           s_tdata,  // pan_value[31:0], tilt_value[63:32]
	input  logic [1:0]            s_tuser,  // req_type[1:0]
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// step_pan_out[0], dir_pan_out[1], step_tilt_out[2], dir_tilt_out[3],
	// busy_res[4], done_res[5], pan_position[37:6], tilt_position[69:38], zero fill
	input  logic [71:0]           m_tdata,
	input  logic [1:0]            m_tuser,  // status[1:0]
	output int                    mismatches,
	output int                    outstanding,
	output logic                  motion_busy
);

	// Shadow registers
	logic                drv_ready;
	logic [TICKS_W-1:0]  high_cfg;
	logic [TICKS_W-1:0]  period_cfg;
	logic [TIMER_W-1:0]  setup_cfg;

	// Motion state
	phase_t              phase;
	logic [TIMER_W-1:0]  timer;
	logic [VALUE_W-1:0]  steps_left;
	logic [VALUE_W-1:0]  pend_pan;
	logic [VALUE_W-1:0]  pend_tilt;
	logic [VALUE_W-1:0]  pos_pan;
	logic [VALUE_W-1:0]  pos_tilt;
	logic [1:0]          dir_lv;     // bit 0 pan, bit 1 tilt
	bit                  move_done;

	result_t             expected_reports[$];
	result_t             want;
	result_t             got;
	int                  report_idx;

	function automatic logic [TICKS_W-1:0] high_len();
		return (high_cfg == '0) ? TICKS_W'(1) : high_cfg;
	endfunction

	// low phase never shorter than one tick
	function automatic logic [TICKS_W-1:0] low_len();
		logic [TICKS_W-1:0] h;
		h = high_len();
		return (period_cfg > h) ? period_cfg - h : TICKS_W'(1);
	endfunction

	function automatic void close_move();
		pos_pan    = pos_pan + pend_pan;
		pos_tilt   = pos_tilt + pend_tilt;
		phase      = PH_IDLE;
		timer      = '0;
		steps_left = '0;
		move_done  = 1'b1;
	endfunction

	function automatic void start_axis(input bit tilt_axis, input logic [VALUE_W-1:0] d);
		dir_lv[tilt_axis] = ~d[VALUE_W-1];
		steps_left = d[VALUE_W-1] ? -d : d;
		if (setup_cfg != '0) begin
			if (tilt_axis) phase = PH_TILT_SETUP;
			else phase = PH_PAN_SETUP;
			timer = setup_cfg;
		end else begin
			if (tilt_axis) phase = PH_TILT_HIGH;
			else phase = PH_PAN_HIGH;
			timer = TIMER_W'(high_len());
		end
	endfunction

	function automatic void tilt_or_close();
		if (pend_tilt != '0) start_axis(1'b1, pend_tilt);
		else close_move();
	endfunction

	// timer expired: move to the following phase
	function automatic void next_phase();
		case (phase)
			PH_PAN_SETUP: begin
				phase = PH_PAN_HIGH;
				timer = TIMER_W'(high_len());
			end
			PH_TILT_SETUP: begin
				phase = PH_TILT_HIGH;
				timer = TIMER_W'(high_len());
			end
			PH_PAN_HIGH: begin
				phase = PH_PAN_LOW;
				timer = TIMER_W'(low_len());
			end
			PH_TILT_HIGH: begin
				phase = PH_TILT_LOW;
				timer = TIMER_W'(low_len());
			end
			PH_PAN_LOW, PH_TILT_LOW: begin
				if (steps_left != '0) steps_left--;
				if (steps_left != '0) begin
					if (phase == PH_PAN_LOW) phase = PH_PAN_HIGH;
					else phase = PH_TILT_HIGH;
					timer = TIMER_W'(high_len());
				end else if (phase == PH_PAN_LOW) begin
					tilt_or_close();
				end else begin
					close_move();
				end
			end
			default: begin
				phase = PH_IDLE;
				timer = '0;
			end
		endcase
	endfunction

	// Apply one beat to the motion state and return the levels it should show
	function automatic result_t compute_report(input logic [1:0] req,
		input logic [VALUE_W-1:0] pan_v, input logic [VALUE_W-1:0] tilt_v);
		result_t r;
		r         = '0;
		move_done = 1'b0;
		r.status  = ST_TICK;
		if (req == REQ_MOVE || req == REQ_SET) begin
			if (!drv_ready) begin
				r.status = ST_NOT_RDY;
			end else if (phase != PH_IDLE) begin
				r.status = ST_BUSY;
			end else begin
				r.status = ST_ACCEPTED;
				if (req == REQ_SET) begin
					pan_v  = pan_v - pos_pan;
					tilt_v = tilt_v - pos_tilt;
				end
				pend_pan  = pan_v;
				pend_tilt = tilt_v;
				if (pend_pan != '0) start_axis(1'b0, pend_pan);
				else tilt_or_close();
			end
		end else if (phase != PH_IDLE) begin
			r.step_pan_out  = (phase == PH_PAN_HIGH);
			r.step_tilt_out = (phase == PH_TILT_HIGH);
			if (timer > TIMER_W'(1)) timer--;
			else next_phase();
		end
		r.dir_pan_out   = dir_lv[0];
		r.dir_tilt_out  = dir_lv[1];
		r.busy_res      = (phase != PH_IDLE);
		r.done_res      = move_done;
		r.pan_position  = pos_pan;
		r.tilt_position = pos_tilt;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			if (mismatches < 10)
				$display("%0t: result %0d, %s: expected %0h, got %0h",
					$time, report_idx, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// Watch config writes and both channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_ready   = 1'b1;
			high_cfg    = PULSE_HIGH_RST;
			period_cfg  = STEP_PERIOD_RST;
			setup_cfg   = DIR_SETUP_RST;
			phase       = PH_IDLE;
			timer       = '0;
			steps_left  = '0;
			pend_pan    = '0;
			pend_tilt   = '0;
			pos_pan     = '0;
			pos_tilt    = '0;
			dir_lv      = '0;
			report_idx  = 0;
			expected_reports.delete();
			mismatches  = 0;
			outstanding = 0;
			motion_busy = 1'b0;
		end else begin
			// result beat
			if (m_tvalid && m_tready) begin
				got.step_pan_out  = m_tdata[0];
				got.dir_pan_out   = m_tdata[1];
				got.step_tilt_out = m_tdata[2];
				got.dir_tilt_out  = m_tdata[3];
				got.busy_res      = m_tdata[4];
				got.done_res      = m_tdata[5];
				got.pan_position  = m_tdata[37:6];
				got.tilt_position = m_tdata[69:38];
				got.status        = m_tuser;
				if (expected_reports.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result %0d arrived with no prediction waiting",
							$time, report_idx);
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					check_field("step_pan_out", want.step_pan_out, got.step_pan_out);
					check_field("dir_pan_out", want.dir_pan_out, got.dir_pan_out);
					check_field("step_tilt_out", want.step_tilt_out, got.step_tilt_out);
					check_field("dir_tilt_out", want.dir_tilt_out, got.dir_tilt_out);
					check_field("busy_res", want.busy_res, got.busy_res);
					check_field("done_res", want.done_res, got.done_res);
					check_field("status", want.status, got.status);
					check_field("pan_position", want.pan_position, got.pan_position);
					check_field("tilt_position", want.tilt_position, got.tilt_position);
				end
				report_idx++;
			end

			if (cfg_wr_en) begin
				case (cfg_addr)
					CFG_DRIVER_READY: drv_ready  = cfg_wdata[0];
					CFG_PULSE_HIGH:   high_cfg   = cfg_wdata[TICKS_W-1:0];
					CFG_STEP_PERIOD:  period_cfg = cfg_wdata[TICKS_W-1:0];
					CFG_DIR_SETUP:    setup_cfg  = cfg_wdata[TIMER_W-1:0];
					default: ;
				endcase
			end

			// input beat
			if (s_tvalid && s_tready)
				expected_reports.push_back(compute_report(s_tuser,
					s_tdata[31:0], s_tdata[63:32]));

			outstanding = expected_reports.size();
			motion_busy = (phase != PH_IDLE);
		end
	end

endmodule

// ===== tb/tb_two_axis_step_dir_generator_core.sv =====
`timescale 1ns / 1ps

module tb_two_axis_step_dir_generator_core;
	import tasdg_pkg::*;

	// request code with no meaning of its own, handled as a tick
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [63:0]           s_tdata   = '0;  // pan_value[31:0], tilt_value[63:32]
	logic [1:0]            s_tuser   = '0;  // req_type[1:0]
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	// step_pan_out[0], dir_pan_out[1], step_tilt_out[2], dir_tilt_out[3],
	// busy_res[4], done_res[5], pan_position[37:6], tilt_position[69:38], zero fill
	logic [71:0]           m_tdata;
	logic [1:0]            m_tuser;         // status[1:0]

	int   mismatches;
	int   outstanding;
	logic motion_busy;

	bit   src_idle  = 1'b1;
	bit   sink_idle = 1'b1;
	int   sink_hold = 0;
	bit   drv_on    = 1'b1;
	int   beats_sent = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	two_axis_step_dir_generator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	step_dir_checker motion_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.motion_busy (motion_busy)
	);

	// Called at a falling edge; returns at the falling edge after the beat is taken
	task automatic send_beat(input logic [1:0] req, input logic [31:0] pan_v,
		input logic [31:0] tilt_v);
		int gap;
		gap = src_idle ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {tilt_v, pan_v};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		beats_sent++;
	endtask

	// tick with junk payload, now and then on the unused code
	task automatic send_tick();
		send_beat(($urandom_range(0, 7) == 0) ? REQ_UNUSED : REQ_TICK, $urandom, $urandom);
	endtask

	task automatic run_out_move();
		while (motion_busy) send_tick();
	endtask

	// stop offering and wait for every predicted result
	task automatic settle();
		s_tvalid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
		if (idx == CFG_DRIVER_READY) drv_on = val[0];
	endtask

	task automatic set_timing(input int high_t, input int period_t, input int setup_t);
		write_reg(CFG_PULSE_HIGH, CFG_DATA_W'(high_t));
		write_reg(CFG_STEP_PERIOD, CFG_DATA_W'(period_t));
		write_reg(CFG_DIR_SETUP, CFG_DATA_W'(setup_t));
	endtask

	// move or set with a few steps per axis
	task automatic small_command();
		int p;
		int t;
		p = int'($urandom_range(0, 8)) - 4;
		t = int'($urandom_range(0, 8)) - 4;
		if ($urandom_range(0, 2) == 0) send_beat(REQ_SET, p, t);
		else send_beat(REQ_MOVE, p, t);
	endtask

	// any code; full-range values only where the command cannot start a move
	task automatic noise_beat();
		logic [1:0] req;
		req = 2'($urandom_range(0, 3));
		if ((req == REQ_MOVE || req == REQ_SET) && drv_on && !motion_busy)
			small_command();
		else
			send_beat(req, $urandom, $urandom);
	endtask

	// Result side: random stall per beat, or a long hold when asked
	initial begin : sink
		int w;
		wait (arst_n);
		@(negedge clk);
		forever begin
			w = sink_idle ? $urandom_range(0, 15) : 0;
			if (sink_hold > 0) begin
				w = sink_hold;
				sink_hold = 0;
			end
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			@(negedge clk);
		end
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin : stim
		int  start_cnt;
		int  kind;
		int  n;
		bit  held;
		held = 1'b0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset timing is slow: only zero-length work here
		send_tick();
		send_beat(REQ_MOVE, 0, 0);
		send_beat(REQ_UNUSED, '1, '1);
		settle();
		write_reg(CFG_DRIVER_READY, CFG_DATA_W'(1));
		set_timing(2, 5, 3);

		// single-axis moves both ways, then both axes
		send_beat(REQ_MOVE, 3, 0);
		run_out_move();
		send_beat(REQ_MOVE, 0, -2);
		run_out_move();
		send_beat(REQ_MOVE, -1, 2);
		send_tick();
		// commands while running are turned away
		send_beat(REQ_MOVE, 32'h7fff_ffff, 32'h8000_0000);
		send_beat(REQ_SET, 32'h8000_0000, 32'hffff_ffff);
		run_out_move();
		send_beat(REQ_SET, 5, -5);
		run_out_move();
		// zeroing, then a set onto the current spot and an empty move
		send_beat(REQ_SET, 0, 0);
		run_out_move();
		send_beat(REQ_SET, 0, 0);
		send_beat(REQ_MOVE, 0, 0);

		// driver not ready: every command fails
		settle();
		write_reg(CFG_DRIVER_READY, CFG_DATA_W'(0));
		send_beat(REQ_MOVE, 32'h7fff_ffff, 32'h8000_0000);
		send_beat(REQ_SET, 32'h8000_0000, 32'h7fff_ffff);
		send_beat(REQ_MOVE, '1, 0);
		send_tick();
		settle();
		write_reg(CFG_DRIVER_READY, CFG_DATA_W'(1));

		// zero high time still lasts a tick; no setup wait
		set_timing(0, 2, 0);
		send_beat(REQ_MOVE, 2, -2);
		run_out_move();
		// high longer than the period: low phase floors at one tick
		settle();
		set_timing(5, 3, 1);
		send_beat(REQ_MOVE, 1, 1);
		run_out_move();
		settle();
		set_timing(1, 2, 0);
		send_beat(REQ_MOVE, -3, -1);
		run_out_move();

		// Random part
		settle();
		set_timing(2, 6, 2);
		start_cnt = beats_sent;
		while (beats_sent - start_cnt < 350) begin
			src_idle  = ($urandom_range(0, 3) != 0);
			sink_idle = ($urandom_range(0, 3) != 0);
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				// retune between moves
				run_out_move();
				settle();
				write_reg(CFG_DRIVER_READY,
					CFG_DATA_W'(($urandom_range(0, 5) == 0) ? 0 : 1));
				set_timing($urandom_range(1, 5), $urandom_range(2, 8), $urandom_range(0, 6));
			end else if (kind <= 6) begin
				// command, then ticks with stray commands mixed in
				small_command();
				n = $urandom_range(0, 40);
				repeat (n) begin
					if ($urandom_range(0, 7) == 0) noise_beat();
					else send_tick();
				end
				if ($urandom_range(0, 1)) run_out_move();
			end else begin
				repeat ($urandom_range(1, 6)) noise_beat();
			end

			// result side holds off while beats keep coming, then a full drain
			if (!held && beats_sent - start_cnt >= 200) begin
				held = 1'b1;
				sink_hold = 64;
				src_idle = 1'b0;
				repeat (40) send_tick();
				settle();
			end
		end

		// widest pulse: one pan step at the top of the timing ranges, left high
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		run_out_move();
		settle();
		write_reg(CFG_DRIVER_READY, CFG_DATA_W'(1));
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		set_timing(16'hfffe, 16'hffff, 0);
		send_beat(REQ_MOVE, 1, 0);
		repeat (40) send_tick();

		// longest setup and the largest step counts, offered while still running
		settle();
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		set_timing(3, 7, 20'hfffff);
		send_beat(REQ_MOVE, 32'h8000_0000, 32'h7fff_ffff);
		repeat (40) noise_beat();

		settle();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
